/* src/pcx_pkg.sv */
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared types and constants of the PCX run-length line encoder.
// ----------------------------------------------------------------------------
package pcx_pkg;

  localparam int COLUMN_BITS_DEFAULT = 16;
  localparam int WIDTH_BITS          = 16;

  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam logic [5:0] RUN_MAX  = 6'd63;

  // op queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // byte slots of one op, in emission order
  localparam int SLOT_A_HDR = 0;
  localparam int SLOT_A_VAL = 1;
  localparam int SLOT_B_HDR = 2;
  localparam int SLOT_B_VAL = 3;
  localparam int SLOT_PAD   = 4;
  localparam int NUM_SLOTS  = 5;

  // one classified pixel: up to two run flushes and a pad byte
  typedef struct packed {
    logic       a_vld;
    logic [7:0] a_val;
    logic [5:0] a_cnt;
    logic       b_vld;
    logic [7:0] b_val;
    logic [5:0] b_cnt;
    logic       pad;
    logic       eol;
  } op_t;

  function automatic logic is_literal(logic [7:0] val, logic [5:0] cnt);
    return (cnt == 6'd1) && (val < RUN_MARK);
  endfunction

  function automatic logic [NUM_SLOTS-1:0] slot_enables(op_t op);
    logic [NUM_SLOTS-1:0] en;
    en = '0;
    en[SLOT_A_HDR] = op.a_vld && !is_literal(op.a_val, op.a_cnt);
    en[SLOT_A_VAL] = op.a_vld;
    en[SLOT_B_HDR] = op.b_vld && !is_literal(op.b_val, op.b_cnt);
    en[SLOT_B_VAL] = op.b_vld;
    en[SLOT_PAD]   = op.pad;
    return en;
  endfunction

endpackage

/* src/pcx_rle_line_encoder.sv */
// ----------------------------------------------------------------------------
// pcx_rle_line_encoder
// PCX run-length scanline encoder: pixel bytes in, code bytes out.
// ----------------------------------------------------------------------------
// Path: a pixel's op crosses the queue, current-op and output registers.
// Throughput: one pixel per cycle in, one code byte per cycle out, set by the
//   back end's byte sequencer, unless stalled; a four-op queue absorbs bursts.
// Reset: synchronous; clears run, column, queue and output; line_width = 1.
module pcx_rle_line_encoder #(
  parameter int COLUMN_BITS = pcx_pkg::COLUMN_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pcx_pkg::WIDTH_BITS-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     code_byte,
  output logic                           end_of_burst,
  output logic                           end_of_line
);

  pcx_pkg::op_t front_op;
  pcx_pkg::op_t head_op;
  logic         accept;
  logic         push;
  logic         pop;
  logic         q_empty;
  logic         q_full;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  pcx_front #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .pixel     (pixel),
    .push      (push),
    .op        (front_op)
  );

  pcx_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (front_op),
    .pop     (pop),
    .head    (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  pcx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head_op),
    .empty        (q_empty),
    .pop          (pop),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .code_byte    (code_byte),
    .end_of_burst (end_of_burst),
    .end_of_line  (end_of_line)
  );

  // a line always closes on the last byte of a burst
  a_eol_ends_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!end_of_line || end_of_burst))
    else $error("end_of_line without end_of_burst");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("op pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_empty))
    else $error("op popped from empty queue");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

/* src/pcx_front.sv */
// ----------------------------------------------------------------------------
// pcx_front
// Takes pixels, tracks the pending run and the column, and turns each pixel
// into an op that lists the run flushes and pad byte it causes.
// ----------------------------------------------------------------------------
module pcx_front #(
  parameter int COLUMN_BITS = pcx_pkg::COLUMN_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pcx_pkg::WIDTH_BITS-1:0] cfg_data,
  input  logic                           accept,
  input  logic [7:0]                     pixel,
  output logic                           push,
  output pcx_pkg::op_t                   op
);

  localparam int CMP_BITS = pcx_pkg::WIDTH_BITS + 1;

  logic [pcx_pkg::WIDTH_BITS-1:0] line_width;
  logic [7:0]                     run_value;
  logic [5:0]                     run_count;
  logic [COLUMN_BITS-1:0]         column;

  logic                   flush_a;
  logic [7:0]             value_next;
  logic [5:0]             count_next;
  logic [CMP_BITS-1:0]    col_inc;
  logic                   line_end;

  always_comb begin
    flush_a = (run_count != 6'd0) &&
              ((pixel != run_value) || (run_count >= pcx_pkg::RUN_MAX));
    if ((run_count != 6'd0) && !flush_a) begin
      value_next = run_value;
      count_next = run_count + 6'd1;
    end else begin
      value_next = pixel;
      count_next = 6'd1;
    end
    col_inc  = {{(CMP_BITS-COLUMN_BITS){1'b0}}, column} + CMP_BITS'(1);
    line_end = col_inc >= {1'b0, line_width};

    op.a_vld = flush_a;
    op.a_val = run_value;
    op.a_cnt = run_count;
    op.b_vld = line_end;
    op.b_val = value_next;
    op.b_cnt = count_next;
    op.pad   = line_end && line_width[0];
    op.eol   = line_end;
  end

  assign push = accept && (flush_a || line_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= pcx_pkg::WIDTH_BITS'(1);
      run_value  <= '0;
      run_count  <= '0;
      column     <= '0;
    end else begin
      if (cfg_write) begin
        line_width <= cfg_data;
      end
      if (accept) begin
        run_value <= value_next;
        if (line_end) begin
          run_count <= '0;
          column    <= '0;
        end else begin
          run_count <= count_next;
          column    <= col_inc[COLUMN_BITS-1:0];
        end
      end
    end
  end

endmodule

/* src/pcx_queue.sv */
// ----------------------------------------------------------------------------
// pcx_queue
// Short first-in first-out queue of ops between front and back.
// ----------------------------------------------------------------------------
module pcx_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  pcx_pkg::op_t push_op,
  input  logic         pop,
  output pcx_pkg::op_t head,
  output logic         empty,
  output logic         full
);

  pcx_pkg::op_t                   entries [pcx_pkg::QUEUE_DEPTH];
  logic [pcx_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [pcx_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [pcx_pkg::QCNT_BITS-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == pcx_pkg::QCNT_BITS'(pcx_pkg::QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + pcx_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + pcx_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + pcx_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - pcx_pkg::QCNT_BITS'(1);
      end
    end
  end

endmodule

/* src/pcx_back.sv */
// ----------------------------------------------------------------------------
// pcx_back
// Expands ops into output-register code bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module pcx_back (
  input  logic         clk,
  input  logic         rst,
  input  pcx_pkg::op_t head,
  input  logic         empty,
  output logic         pop,
  input  logic         out_stall,
  output logic         out_valid,
  output logic [7:0]   code_byte,
  output logic         end_of_burst,
  output logic         end_of_line
);

  pcx_pkg::op_t                  cur;
  logic                          cur_valid;
  logic [pcx_pkg::NUM_SLOTS-1:0] remain;

  logic                          load;
  logic                          emit;
  logic [pcx_pkg::NUM_SLOTS-1:0] pick;
  logic [pcx_pkg::NUM_SLOTS-1:0] remain_next;
  logic                          last;
  logic [7:0]                    byte_next;

  always_comb begin
    load        = !out_valid || !out_stall;
    emit        = cur_valid && load;
    pick        = remain & (~remain + pcx_pkg::NUM_SLOTS'(1));
    remain_next = remain & ~pick;
    last        = (remain_next == '0);
    pop         = !empty && (!cur_valid || (emit && last));

    byte_next = 8'h00;
    if (pick[pcx_pkg::SLOT_A_HDR]) begin
      byte_next = pcx_pkg::RUN_MARK | {2'b00, cur.a_cnt};
    end else if (pick[pcx_pkg::SLOT_A_VAL]) begin
      byte_next = cur.a_val;
    end else if (pick[pcx_pkg::SLOT_B_HDR]) begin
      byte_next = pcx_pkg::RUN_MARK | {2'b00, cur.b_cnt};
    end else if (pick[pcx_pkg::SLOT_B_VAL]) begin
      byte_next = cur.b_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      remain    <= '0;
    end else if (pop) begin
      cur       <= head;
      remain    <= pcx_pkg::slot_enables(head);
      cur_valid <= 1'b1;
    end else if (emit) begin
      remain <= remain_next;
      if (last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid    <= 1'b1;
      code_byte    <= byte_next;
      end_of_burst <= last;
      end_of_line  <= last && cur.eol;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
